// ===== hdl/ntcadc_pkg.sv =====
// shared types, constants and reset values for the ntc adc to temperature converter
package ntcadc_pkg;

  localparam int unsigned ADC_W        = 12;
  localparam int unsigned ENTRY_IDX_W  = 4;
  localparam int unsigned OHMS_W       = 32;
  localparam int unsigned TEMP_W       = 16;
  localparam int unsigned DMV_W        = 16;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned STATUS_W     = 2;

  localparam int unsigned NUM_W        = 48;
  localparam int unsigned DEN_W        = 32;
  localparam int unsigned CNT_W        = 6;
  localparam int unsigned RES_QBITS    = 48;
  localparam int unsigned INTERP_QBITS = 16;

  localparam int unsigned DEF_MAX_ANCHORS    = 16;
  localparam int unsigned DEF_ADC_FULL_SCALE = 4095;
  localparam int unsigned DEF_REF_MILLIVOLTS = 3300;
  localparam int unsigned MIN_ANCHORS        = 2;

  localparam int unsigned RAIL_HI_NUM = 95;
  localparam int unsigned RAIL_HI_DEN = 100;
  localparam int unsigned RAIL_LO_DEN = 10;

  localparam logic                  RST_UPPER_POSITION = 1'b0;
  localparam logic [DMV_W-1:0]      RST_DIVIDER_MV     = 16'd3300;
  localparam logic [OHMS_W-1:0]     RST_DIVIDER_OHMS   = 32'd10000;
  localparam logic [COUNT_W-1:0]    RST_ANCHOR_COUNT   = 5'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPPER_POSITION = 2'd0,
    CFG_DIVIDER_MV     = 2'd1,
    CFG_DIVIDER_OHMS   = 2'd2,
    CFG_ANCHOR_COUNT   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ACT_ANCHOR  = 1'b0,
    ACT_CONVERT = 1'b1
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_INTERP = 2'd0,
    STAT_ABOVE  = 2'd1,
    STAT_BELOW  = 2'd2,
    STAT_FAULT  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    DIV_RES,
    DIV_INTERP
  } div_mode_e;

  typedef struct packed {
    logic      start;
    div_mode_e mode;
  } div_req_t;

  typedef struct packed {
    logic        [OHMS_W-1:0] ohms;
    logic signed [TEMP_W-1:0] temp;
  } anchor_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MV,
    S_CHECK,
    S_RSTART,
    S_RES,
    S_SRCH,
    S_DIFF,
    S_MUL,
    S_IDIV,
    S_FAULT_RD,
    S_FAULT,
    S_EMIT
  } state_e;

endpackage

// ===== hdl/ntcadc_ram.sv =====
// generic single-write, single-read ram with registered read data
module ntcadc_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ntcadc_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle, start offset per operand kind
module ntcadc_div
  import ntcadc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [NUM_W-1:0] nq_q, nq_d;
  logic [DEN_W+1:0] trial;

  assign trial = {1'b0, rem_q, nq_q[NUM_W-1]} - {2'b00, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    nq_d   = nq_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      den_d  = den_i;
      unique case (req_i.mode)
        DIV_RES: begin
          rem_d = '0;
          nq_d  = num_i;
          cnt_d = CNT_W'(RES_QBITS);
        end
        DIV_INTERP: begin
          rem_d = DEN_W'(num_i >> INTERP_QBITS);
          nq_d  = num_i << (NUM_W - INTERP_QBITS);
          cnt_d = CNT_W'(INTERP_QBITS);
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - CNT_W'(1);
        if (!trial[DEN_W+1]) begin
          rem_d = trial[DEN_W-1:0];
        end else begin
          rem_d = {rem_q[DEN_W-2:0], nq_q[NUM_W-1]};
        end
        nq_d = {nq_q[NUM_W-2:0], !trial[DEN_W+1]};
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    nq_q  <= nq_d;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o  = nq_q;

endmodule

// ===== hdl/ntc_adc_to_temperature.sv =====
// ntc divider adc code to temperature converter, top level
//
//   channel | direction | handshake                 | payload
//   in      | sink      | in_valid_i / in_stall_o   | action, adc_code, entry_index/ohms/temp
//   out     | source    | out_valid_o / out_stall_i | temperature, status
//   cfg     | sink      | cfg_we_i, cfg_idx_i       | cfg_wdata_i
//
// an anchor write item is written straight into the anchor ram and gives no result
// a conversion runs a resistance division, a search down the anchor table from the last of the
//   n anchors, n the saturated anchor count, and, between two anchors, an interpolation division;
//   a sensor fault skips all three
// reset loads the register defaults; the anchor ram is not cleared
// the input stalls while a conversion runs and while its result waits on a stalled output
module ntc_adc_to_temperature
  import ntcadc_pkg::*;
#(
  parameter int unsigned MAX_ANCHORS    = DEF_MAX_ANCHORS,
  parameter int unsigned ADC_FULL_SCALE = DEF_ADC_FULL_SCALE,
  parameter int unsigned REF_MILLIVOLTS = DEF_REF_MILLIVOLTS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     action_i,
  input  logic [ADC_W-1:0]         adc_code_i,
  input  logic [ENTRY_IDX_W-1:0]   entry_index_i,
  input  logic [OHMS_W-1:0]        entry_ohms_i,
  input  logic signed [TEMP_W-1:0] entry_temp_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [TEMP_W-1:0] temperature_o,
  output logic [STATUS_W-1:0]      status_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned AW          = $clog2(MAX_ANCHORS);
  localparam int unsigned MV_MAX      = ((2 ** ADC_W - 1) * REF_MILLIVOLTS) / ADC_FULL_SCALE;
  localparam int unsigned MV_W        = $clog2(MV_MAX + 1);
  localparam int unsigned RAIL_HI_LIM = ADC_FULL_SCALE * RAIL_HI_NUM;
  localparam int unsigned MVX_W       = $clog2((2 ** ADC_W - 1) * REF_MILLIVOLTS + 1);
  localparam int unsigned MV_SHIFT    = MVX_W + $clog2(ADC_FULL_SCALE);
  localparam longint unsigned MV_RECIP =
    ((64'd1 << MV_SHIFT) + ADC_FULL_SCALE - 1) / ADC_FULL_SCALE;
  localparam longint unsigned MV_SCALE = MV_RECIP * REF_MILLIVOLTS;

  state_e state_q, state_d;

  logic                upper_q, upper_d;
  logic [DMV_W-1:0]    dmv_q, dmv_d;
  logic [OHMS_W-1:0]   dohms_q, dohms_d;
  logic [COUNT_W-1:0]  count_q, count_d;

  logic [ADC_W-1:0]    adc_q, adc_d;
  logic [MV_W-1:0]     mv_q, mv_d;
  logic [DMV_W-1:0]    fac_q, fac_d;
  logic [DMV_W-1:0]    dvs_q, dvs_d;
  logic [NUM_W-1:0]    r_q, r_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic [AW-1:0]       cur_q, cur_d;
  logic                rd_vld_q, rd_vld_d;
  anchor_t             seg_hi_q, seg_hi_d;
  anchor_t             seg_lo_q, seg_lo_d;
  logic [OHMS_W-1:0]   numr_q, numr_d;
  logic [DEN_W-1:0]    dvsi_q, dvsi_d;
  logic                dneg_q, dneg_d;
  logic [TEMP_W-1:0]   dmag_q, dmag_d;
  logic [TEMP_W-1:0]   res_temp_q, res_temp_d;
  status_e             res_stat_q, res_stat_d;
  logic                out_vld_q, out_vld_d;
  logic [TEMP_W-1:0]   out_temp_q, out_temp_d;
  status_e             out_stat_q, out_stat_d;

  logic                accept;
  logic                emit_ok;
  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  logic [$bits(anchor_t)-1:0] ram_rdata;
  anchor_t             rd_ent;
  logic [AW-1:0]       last_idx;
  logic                hit;
  logic                fault;
  logic [DMV_W-1:0]    mv16;
  logic [63:0]         mv_prod;
  logic signed [TEMP_W:0] diff;
  logic [TEMP_W:0]     diff_abs;
  logic [TEMP_W-1:0]   q16;

  div_req_t            div_req;
  logic [NUM_W-1:0]    div_num;
  logic [DEN_W-1:0]    div_den;
  logic                div_done;
  logic [NUM_W-1:0]    div_quo;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign emit_ok    = !out_vld_q || !out_stall_i;
  assign rd_ent     = anchor_t'(ram_rdata);
  assign hit        = r_q < NUM_W'(rd_ent.ohms);
  assign mv16       = DMV_W'(mv_q);
  assign q16        = div_quo[TEMP_W-1:0];

  // millivolts by reciprocal multiplication, exact over the whole adc range
  assign mv_prod    = 64'(adc_q) * MV_SCALE;

  assign ram_we = accept && (action_i == ACT_ANCHOR) && (32'(entry_index_i) < MAX_ANCHORS);

  // last anchor index, from the anchor count saturated to between MIN_ANCHORS and the table size
  always_comb begin
    if (32'(count_q) < MIN_ANCHORS) begin
      last_idx = AW'(MIN_ANCHORS - 1);
    end else if (32'(count_q) > MAX_ANCHORS) begin
      last_idx = AW'(MAX_ANCHORS - 1);
    end else begin
      last_idx = AW'(count_q - COUNT_W'(1));
    end
  end

  // near rail and bad divisor checks
  always_comb begin
    if (!upper_q) begin
      fault = (32'(adc_q) * RAIL_HI_DEN > RAIL_HI_LIM) || (32'(dmv_q) <= 32'(mv_q));
    end else begin
      fault = (32'(adc_q) * RAIL_LO_DEN < ADC_FULL_SCALE) || (mv_q == '0)
              || (32'(dmv_q) < 32'(mv_q));
    end
  end

  always_comb begin
    diff     = {seg_lo_q.temp[TEMP_W-1], seg_lo_q.temp} - {seg_hi_q.temp[TEMP_W-1], seg_hi_q.temp};
    diff_abs = diff[TEMP_W] ? ((TEMP_W+1)'(0) - diff) : diff;
  end

  always_comb begin
    upper_d = upper_q;
    dmv_d   = dmv_q;
    dohms_d = dohms_q;
    count_d = count_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_UPPER_POSITION: upper_d = cfg_wdata_i[0];
        CFG_DIVIDER_MV:     dmv_d   = cfg_wdata_i[DMV_W-1:0];
        CFG_DIVIDER_OHMS:   dohms_d = cfg_wdata_i[OHMS_W-1:0];
        CFG_ANCHOR_COUNT:   count_d = cfg_wdata_i[COUNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (action_i == ACT_CONVERT)) begin
          state_d = S_MV;
        end
      end
      S_MV:     state_d = S_CHECK;
      S_CHECK:  state_d = fault ? S_FAULT_RD : S_RSTART;
      S_RSTART: state_d = S_RES;
      S_RES: begin
        if (div_done) begin
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (rd_vld_q && (hit || (cur_q == '0))) begin
          state_d = (hit && (cur_q != last_idx)) ? S_DIFF : S_EMIT;
        end
      end
      S_DIFF: state_d = S_MUL;
      S_MUL:  state_d = S_IDIV;
      S_IDIV: begin
        if (div_done) begin
          state_d = S_EMIT;
        end
      end
      S_FAULT_RD: state_d = S_FAULT;
      S_FAULT:    state_d = S_EMIT;
      S_EMIT: begin
        if (emit_ok) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    adc_d      = adc_q;
    mv_d       = mv_q;
    fac_d      = fac_q;
    dvs_d      = dvs_q;
    r_d        = r_q;
    ptr_d      = ptr_q;
    cur_d      = cur_q;
    rd_vld_d   = rd_vld_q;
    seg_hi_d   = seg_hi_q;
    seg_lo_d   = seg_lo_q;
    numr_d     = numr_q;
    dvsi_d     = dvsi_q;
    dneg_d     = dneg_q;
    dmag_d     = dmag_q;
    res_temp_d = res_temp_q;
    res_stat_d = res_stat_q;
    out_temp_d = out_temp_q;
    out_stat_d = out_stat_q;
    out_vld_d  = out_vld_q && out_stall_i;
    ram_raddr  = '0;
    div_req    = '{start: 1'b0, mode: DIV_RES};
    div_num    = '0;
    div_den    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (action_i == ACT_CONVERT)) begin
          adc_d = adc_code_i;
        end
      end
      S_MV: begin
        mv_d = MV_W'(mv_prod >> MV_SHIFT);
      end
      S_CHECK: begin
        fac_d = upper_q ? (dmv_q - mv16) : mv16;
        dvs_d = upper_q ? mv16 : (dmv_q - mv16);
      end
      S_RSTART: begin
        div_req = '{start: 1'b1, mode: DIV_RES};
        div_num = NUM_W'(fac_q) * NUM_W'(dohms_q);
        div_den = DEN_W'(dvs_q);
      end
      S_RES: begin
        if (div_done) begin
          r_d      = div_quo;
          ptr_d    = last_idx;
          rd_vld_d = 1'b0;
        end
      end
      S_SRCH: begin
        // one entry read per cycle, walking from the last anchor down
        ram_raddr = ptr_q;
        ptr_d     = ptr_q - AW'(1);
        cur_d     = ptr_q;
        rd_vld_d  = 1'b1;
        if (rd_vld_q) begin
          if (hit) begin
            seg_hi_d = rd_ent;
            if (cur_q == last_idx) begin
              res_temp_d = rd_ent.temp;
              res_stat_d = STAT_ABOVE;
            end
          end else begin
            seg_lo_d = rd_ent;
            if (cur_q == '0) begin
              res_temp_d = rd_ent.temp;
              res_stat_d = STAT_BELOW;
            end
          end
        end
      end
      S_DIFF: begin
        numr_d = seg_hi_q.ohms - r_q[OHMS_W-1:0];
        dvsi_d = seg_hi_q.ohms - seg_lo_q.ohms;
        dneg_d = diff[TEMP_W];
        dmag_d = diff_abs[TEMP_W-1:0];
      end
      S_MUL: begin
        div_req = '{start: 1'b1, mode: DIV_INTERP};
        div_num = NUM_W'(numr_q) * NUM_W'(dmag_q);
        div_den = dvsi_q;
      end
      S_IDIV: begin
        if (div_done) begin
          res_temp_d = seg_hi_q.temp + (dneg_q ? (TEMP_W'(0) - q16) : q16);
          res_stat_d = STAT_INTERP;
        end
      end
      S_FAULT_RD: begin
        ram_raddr = '0;
      end
      S_FAULT: begin
        res_temp_d = rd_ent.temp;
        res_stat_d = STAT_FAULT;
      end
      S_EMIT: begin
        if (emit_ok) begin
          out_temp_d = res_temp_q;
          out_stat_d = res_stat_q;
          out_vld_d  = 1'b1;
        end
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  ntcadc_ram #(
    .WIDTH($bits(anchor_t)),
    .DEPTH(MAX_ANCHORS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i ({entry_ohms_i, entry_temp_i}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ntcadc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      upper_q   <= RST_UPPER_POSITION;
      dmv_q     <= RST_DIVIDER_MV;
      dohms_q   <= RST_DIVIDER_OHMS;
      count_q   <= RST_ANCHOR_COUNT;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      upper_q   <= upper_d;
      dmv_q     <= dmv_d;
      dohms_q   <= dohms_d;
      count_q   <= count_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    adc_q      <= adc_d;
    mv_q       <= mv_d;
    fac_q      <= fac_d;
    dvs_q      <= dvs_d;
    r_q        <= r_d;
    ptr_q      <= ptr_d;
    cur_q      <= cur_d;
    seg_hi_q   <= seg_hi_d;
    seg_lo_q   <= seg_lo_d;
    numr_q     <= numr_d;
    dvsi_q     <= dvsi_d;
    dneg_q     <= dneg_d;
    dmag_q     <= dmag_d;
    res_temp_q <= res_temp_d;
    res_stat_q <= res_stat_d;
    out_temp_q <= out_temp_d;
    out_stat_q <= out_stat_d;
  end

  assign out_valid_o   = out_vld_q;
  assign temperature_o = out_temp_q;
  assign status_o      = out_stat_q;

`ifndef NO_ASSERTIONS
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_RES || state_q == S_IDIV))
    else $error("divider finished outside a wait state");

  a_search_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH && rd_vld_q) |-> (cur_q <= last_idx))
    else $error("anchor search left the table");

  a_emit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_vld_q && out_stall_i) |=> (state_q == S_EMIT))
    else $error("result dropped while output slot full");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == S_EMIT))
    else $error("output item raised outside emit");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the ntc adc to temperature converter with a reading scoreboard
import ntcadc_pkg::*;

typedef struct packed {
  logic signed [TEMP_W-1:0] temp;
  status_e                  status;
} reading_t;

class reading_scoreboard;
  logic                     upper_position;
  logic [DMV_W-1:0]         divider_mv;
  logic [OHMS_W-1:0]        divider_ohms;
  logic [COUNT_W-1:0]       anchor_count;
  logic [OHMS_W-1:0]        anchor_ohms [DEF_MAX_ANCHORS];
  logic signed [TEMP_W-1:0] anchor_temp [DEF_MAX_ANCHORS];
  reading_t                 expected_readings[$];
  int                       failures;

  function new();
    upper_position = RST_UPPER_POSITION;
    divider_mv     = RST_DIVIDER_MV;
    divider_ohms   = RST_DIVIDER_OHMS;
    anchor_count   = RST_ANCHOR_COUNT;
    failures       = 0;
    foreach (anchor_ohms[k]) begin
      anchor_ohms[k] = '0;
      anchor_temp[k] = '0;
    end
  endfunction

  function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_UPPER_POSITION: upper_position = data[0];
      CFG_DIVIDER_MV:     divider_mv = data[DMV_W-1:0];
      CFG_DIVIDER_OHMS:   divider_ohms = data[OHMS_W-1:0];
      CFG_ANCHOR_COUNT:   anchor_count = data[COUNT_W-1:0];
      default: ;
    endcase
  endfunction

  // thermistor resistance, zero where the divisor would not be positive or the numerator negative
  function longint unsigned thermistor_ohms(logic [ADC_W-1:0] adc);
    longint unsigned mv;
    longint unsigned dmv;
    mv  = adc;
    mv  = mv * DEF_REF_MILLIVOLTS / DEF_ADC_FULL_SCALE;
    dmv = divider_mv;
    if (!upper_position) begin
      if (dmv > mv) return mv * divider_ohms / (dmv - mv);
      return 0;
    end
    if (mv != 0 && dmv >= mv) return (dmv - mv) * divider_ohms / mv;
    return 0;
  endfunction

  function reading_t predict_reading(logic [ADC_W-1:0] adc);
    longint unsigned a;
    longint unsigned mv;
    longint unsigned dmv;
    longint unsigned r;
    longint          num;
    longint          den;
    longint          diff;
    longint          t;
    int              n;
    int              hit;
    int              k;
    bit              fault;
    reading_t        res;
    a   = adc;
    mv  = a * DEF_REF_MILLIVOLTS / DEF_ADC_FULL_SCALE;
    dmv = divider_mv;
    n   = anchor_count;
    if (n < MIN_ANCHORS) n = MIN_ANCHORS;
    if (n > DEF_MAX_ANCHORS) n = DEF_MAX_ANCHORS;
    if (!upper_position) begin
      fault = (a * RAIL_HI_DEN > DEF_ADC_FULL_SCALE * RAIL_HI_NUM) || (dmv <= mv);
    end else begin
      fault = (a * RAIL_LO_DEN < DEF_ADC_FULL_SCALE) || (mv == 0) || (dmv < mv);
    end
    if (fault) begin
      res.temp   = anchor_temp[0];
      res.status = STAT_FAULT;
      return res;
    end
    r   = thermistor_ohms(adc);
    hit = -1;
    for (k = 0; k < n; k++) begin
      if (r < anchor_ohms[k]) hit = k;
    end
    if (hit >= n - 1) begin
      res.temp   = anchor_temp[n-1];
      res.status = STAT_ABOVE;
    end else if (hit < 0) begin
      res.temp   = anchor_temp[0];
      res.status = STAT_BELOW;
    end else begin
      num        = longint'(anchor_ohms[hit]) - longint'(r);
      den        = longint'(anchor_ohms[hit]) - longint'(anchor_ohms[hit+1]);
      diff       = longint'(anchor_temp[hit+1]) - longint'(anchor_temp[hit]);
      t          = longint'(anchor_temp[hit]) + num * diff / den;
      res.temp   = t[TEMP_W-1:0];
      res.status = STAT_INTERP;
    end
    return res;
  endfunction

  function void note_item(action_e act, logic [ADC_W-1:0] adc, logic [ENTRY_IDX_W-1:0] idx,
                          logic [OHMS_W-1:0] ohms, logic signed [TEMP_W-1:0] temp);
    if (act == ACT_ANCHOR) begin
      if (idx < DEF_MAX_ANCHORS) begin
        anchor_ohms[idx] = ohms;
        anchor_temp[idx] = temp;
      end
    end else begin
      expected_readings.push_back(predict_reading(adc));
    end
  endfunction

  function void check_reading(logic signed [TEMP_W-1:0] temp, logic [STATUS_W-1:0] status);
    reading_t want;
    if (expected_readings.size() == 0) begin
      failures++;
      $display("%0t: reading with none expected, temperature %0d status %0d",
               $time, temp, status);
      return;
    end
    want = expected_readings.pop_front();
    if (temp !== want.temp) begin
      failures++;
      $display("%0t: temperature expected %0d actual %0d", $time, want.temp, temp);
    end
    if (status !== want.status) begin
      failures++;
      $display("%0t: status expected %0d actual %0d", $time, want.status, status);
    end
  endfunction
endclass

module testbench;

  localparam int     SETTLE_CYCLES = 150;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     NUM_PHASES    = 12;
  localparam int     RANDOM_ITEMS  = 55;
  localparam longint TIMEOUT_NS    = 20_000_000;

  typedef enum int {
    RX_FREE,
    RX_RANDOM,
    RX_PERIODIC,
    RX_HEAVY
  } rx_mode_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     action_i;
  logic [ADC_W-1:0]         adc_code_i;
  logic [ENTRY_IDX_W-1:0]   entry_index_i;
  logic [OHMS_W-1:0]        entry_ohms_i;
  logic signed [TEMP_W-1:0] entry_temp_i;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [TEMP_W-1:0] temperature_o;
  logic [STATUS_W-1:0]      status_o;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [CFG_DATA_W-1:0]    cfg_wdata_i;

  reading_scoreboard sb;
  int                burst_left = 0;
  bit                hold_req   = 1'b0;
  int                hold_left  = 0;
  int                mode_left  = 0;
  rx_mode_e          rx_mode    = RX_FREE;

  ntc_adc_to_temperature dut (.*);

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 300);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else begin
      case (rx_mode)
        RX_FREE:     out_stall_i = 1'b0;
        RX_RANDOM:   out_stall_i = ($urandom_range(0, 2) == 0);
        RX_PERIODIC: out_stall_i = (mode_left % 4 == 0);
        default:     out_stall_i = ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_reading(temperature_o, status_o);
  end

  task automatic offer_item(action_e act, logic [ADC_W-1:0] adc, logic [ENTRY_IDX_W-1:0] idx,
                            logic [OHMS_W-1:0] ohms, logic signed [TEMP_W-1:0] temp);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 16);
    end
    burst_left--;
    action_i      = act;
    adc_code_i    = adc;
    entry_index_i = idx;
    entry_ohms_i  = ohms;
    entry_temp_i  = temp;
    in_valid_i    = 1'b1;
    do begin
      @(posedge clk_i);
    end while (in_stall_o !== 1'b0);
    sb.note_item(act, adc, idx, ohms, temp);
    @(negedge clk_i);
  endtask

  task automatic convert(logic [ADC_W-1:0] adc);
    offer_item(ACT_CONVERT, adc, 4'($urandom), $urandom, 16'($urandom));
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (sb.expected_readings.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic apply_setting(int phase);
    logic                  up;
    logic [DMV_W-1:0]      dmv;
    logic [OHMS_W-1:0]     ohms;
    logic [COUNT_W-1:0]    count;
    case (phase)
      1: begin up = 1'b1; dmv = 16'd3300;  ohms = 32'd10000;      count = 5'd16; end
      2: begin up = 1'b1; dmv = 16'hFFFF;  ohms = 32'hFFFF_FFFF;  count = 5'd31; end
      3: begin up = 1'b0; dmv = 16'd0;     ohms = 32'd0;          count = 5'd0;  end
      4: begin up = 1'b0; dmv = 16'hFFFF;  ohms = 32'd0;          count = 5'd1;  end
      5: begin up = 1'b1; dmv = 16'd5000;  ohms = 32'd100000;     count = 5'd17; end
      default: begin
        up    = 1'($urandom_range(0, 1));
        dmv   = 16'($urandom_range(1000, 5000));
        ohms  = $urandom_range(1000, 200000);
        count = 5'($urandom_range(0, 31));
      end
    endcase
    write_reg(CFG_UPPER_POSITION, CFG_DATA_W'(up));
    write_reg(CFG_DIVIDER_MV, CFG_DATA_W'(dmv));
    write_reg(CFG_DIVIDER_OHMS, ohms);
    write_reg(CFG_ANCHOR_COUNT, CFG_DATA_W'(count));
  endtask

  // descending resistances around the midscale reading, ascending temperatures
  task automatic load_random_table();
    longint unsigned r_mid;
    longint unsigned ohms;
    int              tv;
    int              k;
    r_mid = sb.thermistor_ohms(12'd2048);
    if (r_mid == 0 || r_mid > 64'h1FFF_FFFF) begin
      ohms = $urandom;
    end else begin
      ohms = r_mid * $urandom_range(3, 40);
      if (ohms > 64'hFFFF_FFFF) ohms = 64'hFFFF_FFFF;
    end
    tv = -int'($urandom_range(0, 600));
    for (k = 0; k < DEF_MAX_ANCHORS; k++) begin
      offer_item(ACT_ANCHOR, 12'($urandom), 4'(k), ohms[OHMS_W-1:0], 16'(tv));
      ohms = ohms * $urandom_range(35, 90) / 100;
      tv  += $urandom_range(0, 250);
    end
  endtask

  task automatic random_item();
    int               pick;
    logic [ADC_W-1:0] adc;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      offer_item(ACT_ANCHOR, 12'($urandom), 4'($urandom), $urandom, 16'($urandom));
    end else begin
      if (pick < 25) begin
        adc = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(380, 440))
                                          : 12'($urandom_range(3860, 3920));
      end else begin
        adc = 12'($urandom);
      end
      convert(adc);
    end
  endtask

  initial begin
    int phase;
    int k;
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    action_i      = ACT_CONVERT;
    adc_code_i    = '0;
    entry_index_i = '0;
    entry_ohms_i  = '0;
    entry_temp_i  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_UPPER_POSITION;
    cfg_wdata_i   = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings, table with extreme ends
    offer_item(ACT_ANCHOR, 12'hFFF, 4'd0, 32'hFFFF_FFFF, -16'sd32768);
    offer_item(ACT_ANCHOR, 12'h000, 4'd1, 32'd10000, 16'sd25);
    for (k = 2; k < DEF_MAX_ANCHORS - 1; k++) begin
      offer_item(ACT_ANCHOR, 12'($urandom), 4'(k), 32'(10000 - k * 600), 16'(25 + k * 10));
    end
    offer_item(ACT_ANCHOR, 12'($urandom), 4'd15, 32'd0, 16'sd32767);
    convert(12'd0);
    convert(12'd1);
    convert(12'd2048);
    convert(12'd3890);
    convert(12'd3891);
    convert(12'd4095);
    convert(12'd409);
    convert(12'd410);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        wait_idle();
        apply_setting(phase);
        load_random_table();
        convert(12'd0);
        convert(12'd409);
        convert(12'd410);
        convert(12'd3890);
        convert(12'd3891);
        convert(12'd4095);
      end
      if (phase == 1 || phase == 7) hold_req = 1'b1;
      repeat (RANDOM_ITEMS) random_item();
    end

    wait_idle();
    if (sb.failures == 0 && sb.expected_readings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ntcadc_pkg.sv
hdl/ntcadc_ram.sv
hdl/ntcadc_div.sv
hdl/ntc_adc_to_temperature.sv
test/testbench.sv
